// ===== src/rdl_pkg.sv =====
`timescale 1ns / 1ps
package rdl_pkg;

  // fixed field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LIMB_W  = 60;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned RADIX_W = 3;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 2;

  // result queue
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // register map (word index taken from paddr[2])
  localparam logic REG_RADIX_LOG2 = 1'b0;
  localparam logic [RADIX_W-1:0] RADIX_LOG2_RST = 3'd4;
  localparam logic [RADIX_W-1:0] RADIX_LOG2_MIN = 3'd1;
  localparam logic [RADIX_W-1:0] RADIX_LOG2_MAX = 3'd6;
  localparam logic [RADIX_W-1:0] FOLD_MAX_LOG2  = 3'd5;

  // character codes
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

  localparam logic [DIGIT_W-1:0] DIG_PLUS  = 6'd62;
  localparam logic [DIGIT_W-1:0] DIG_SLASH = 6'd63;
  localparam logic [DIGIT_W-1:0] DIG_UPPER = 6'd10;
  localparam logic [DIGIT_W-1:0] DIG_LOWER = 6'd36;

  typedef struct packed {
    logic               ok;     // character is a digit of the radix
    logic [DIGIT_W-1:0] value;
  } digit_t;

  typedef struct packed {
    logic [LIMB_W-1:0] limb_value;
    logic              limb_last;
    logic              negative;
    logic              invalid;
  } result_t;

endpackage

// ===== src/rdl_digit_map.sv =====
`timescale 1ns / 1ps
module rdl_digit_map
  import rdl_pkg::*;
(
  input  logic [CHAR_W-1:0]  char_i,
  input  logic [RADIX_W-1:0] radix_log2_i,  // already clamped to 1..6
  output digit_t             digit_o
);

  logic [CHAR_W-1:0]  folded;
  logic [CHAR_W-1:0]  offs;
  logic [DIGIT_W-1:0] val;
  logic               is_dig;
  logic [DIGIT_W-1:0] high_bits;

  always_comb begin
    folded = char_i;
    if (radix_log2_i <= FOLD_MAX_LOG2 && char_i inside {[CH_LA:CH_LZ]}) begin
      folded = char_i - CASE_GAP;
    end
    offs   = '0;
    val    = '0;
    is_dig = 1'b1;
    if (folded inside {[CH_0:CH_9]}) begin
      offs = folded - CH_0;
      val  = offs[DIGIT_W-1:0];
    end else if (folded inside {[CH_UA:CH_UZ]}) begin
      offs = folded - CH_UA;
      val  = offs[DIGIT_W-1:0] + DIG_UPPER;
    end else if (folded inside {[CH_LA:CH_LZ]}) begin
      offs = folded - CH_LA;
      val  = offs[DIGIT_W-1:0] + DIG_LOWER;
    end else if (folded == CH_PLUS) begin
      val = DIG_PLUS;
    end else if (folded == CH_SLASH) begin
      val = DIG_SLASH;
    end else begin
      is_dig = 1'b0;
    end
    // digit must be below 2^radix_log2
    high_bits     = val >> radix_log2_i;
    digit_o.ok    = is_dig && (high_bits == '0);
    digit_o.value = val;
  end

endmodule

// ===== src/rdl_packer.sv =====
`timescale 1ns / 1ps
module rdl_packer
  import rdl_pkg::*;
#(
  parameter int unsigned LIMB_BITS = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [CHAR_W-1:0]  char_i,
  input  logic               last_i,
  input  logic [RADIX_W-1:0] radix_log2_i,
  input  digit_t             digit_i,
  output result_t            res0_o,
  output result_t            res1_o,
  output logic [1:0]         n_push_o
);

  localparam int unsigned CNT_W = $clog2(LIMB_BITS);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned SH_W  = LIMB_BITS + DIGIT_W;

  logic [LIMB_BITS-1:0] buf_q, buf_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 seen_q, seen_d;
  logic                 disc_q, disc_d;

  logic [SH_W-1:0]      shifted;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_wrap;
  logic                 full;
  logic [LIMB_BITS-1:0] merged;
  logic [LIMB_BITS-1:0] carry;
  logic [LIMB_BITS-1:0] tail;

  always_comb begin
    shifted  = SH_W'(digit_i.value) << cnt_q;
    sum      = SUM_W'(cnt_q) + SUM_W'(radix_log2_i);
    sum_wrap = sum - SUM_W'(LIMB_BITS);
    full     = sum >= SUM_W'(LIMB_BITS);
    merged   = buf_q | shifted[LIMB_BITS-1:0];
    carry    = LIMB_BITS'(shifted[SH_W-1:LIMB_BITS]);
    tail     = full ? carry : merged;
  end

  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    seen_d   = seen_q;
    disc_d   = disc_q;
    res0_o   = '0;
    res1_o   = '0;
    n_push_o = 2'd0;
    if (accept_i) begin
      if (disc_q) begin
        // drop everything up to the end of the number
        if (last_i) begin
          disc_d = 1'b0;
        end
      end else if (last_i && char_i == CH_MINUS) begin
        res0_o.limb_value = LIMB_W'(buf_q);
        res0_o.limb_last  = 1'b1;
        res0_o.negative   = 1'b1;
        n_push_o = 2'd1;
        buf_d    = '0;
        cnt_d    = '0;
        seen_d   = 1'b0;
      end else if (!seen_q && (char_i == CH_CR || char_i == CH_LF)) begin
        if (last_i) begin
          res0_o.limb_value = LIMB_W'(buf_q);
          res0_o.limb_last  = 1'b1;
          n_push_o = 2'd1;
          buf_d    = '0;
          cnt_d    = '0;
        end
      end else if (!digit_i.ok) begin
        res0_o.limb_last = 1'b1;
        res0_o.invalid   = 1'b1;
        n_push_o = 2'd1;
        buf_d    = '0;
        cnt_d    = '0;
        seen_d   = 1'b0;
        disc_d   = !last_i;
      end else begin
        seen_d = 1'b1;
        buf_d  = tail;
        cnt_d  = full ? sum_wrap[CNT_W-1:0] : sum[CNT_W-1:0];
        if (full) begin
          res0_o.limb_value = LIMB_W'(merged);
          res1_o.limb_value = LIMB_W'(tail);
          res1_o.limb_last  = 1'b1;
          n_push_o = last_i ? 2'd2 : 2'd1;
        end else begin
          res0_o.limb_value = LIMB_W'(tail);
          res0_o.limb_last  = 1'b1;
          n_push_o = last_i ? 2'd1 : 2'd0;
        end
        if (last_i) begin
          buf_d  = '0;
          cnt_d  = '0;
          seen_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      disc_q <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      disc_q <= disc_d;
    end
  end

endmodule

// ===== src/rdl_out_queue.sv =====
`timescale 1ns / 1ps
module rdl_out_queue
  import rdl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  result_t          res0_i,
  input  result_t          res1_i,
  input  logic [1:0]       n_push_i,
  input  logic             pop_i,
  output result_t          head_o,
  output logic             not_empty_o,
  output logic             room2_o,
  output logic [Q_CNT_W-1:0] count_o
);

  result_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic [Q_PTR_W-1:0]   wr_next;

  always_comb begin
    wr_next = wr_q + Q_PTR_W'(1);
    wr_d    = wr_q + Q_PTR_W'(n_push_i);
    rd_d    = pop_i ? rd_q + Q_PTR_W'(1) : rd_q;
    cnt_d   = cnt_q + Q_CNT_W'(n_push_i) - Q_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (n_push_i != 2'd0) begin
      mem_q[wr_q] <= res0_i;
    end
    if (n_push_i == 2'd2) begin
      mem_q[wr_next] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o      = mem_q[rd_q];
  assign not_empty_o = cnt_q != '0;
  assign room2_o     = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);
  assign count_o     = cnt_q;

endmodule

// ===== src/pow2_radix_digits_to_limbs_core.sv =====
`timescale 1ns / 1ps
// power-of-two radix string to bignum limbs
//
// slave stream: one ascii character per transaction, least significant first;
//   s_axis_tdata holds char_code, s_axis_tlast marks the most significant
//   character, which ends the number
// master stream: one limb per transaction, least significant limb first;
//   m_axis_tlast marks the final limb (or the single error transaction),
//   m_axis_tuser carries negative and invalid
// apb port: one register, radix_log2 at byte address 0 (bits per digit);
//   write it only while the block is idle
// results of a character are registered in the result queue before they leave
// throughput: one character per cycle while s_axis_tready is high; decode and
//   packing are a single combinational step from the accepted character and the
//   packing state into a four-entry result queue; a character that fills a limb
//   and ends the number pushes two results, so over a long run the queue drains
//   at one limb per cycle while m_axis_tready is high
// stall: s_axis_tready drops only when the queue has fewer than two free
//   entries, so up to two limbs can wait while characters keep flowing
// reset: queue empty, packing state cleared, radix_log2 = 4 (hex)
module pow2_radix_digits_to_limbs_core
  import rdl_pkg::*;
#(
  parameter int unsigned LIMB_BITS = 60
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // character stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_code
  input  logic                   s_axis_tlast,
  // limb stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [59:0] limb_value, rest zero
  output logic                   m_axis_tlast,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] negative, [1] invalid
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [RADIX_W-1:0] radix_eff;
  logic               cfg_wr;
  logic               in_accept;
  logic               out_pop;
  digit_t             digit;
  result_t            res0, res1, head;
  logic [1:0]         n_push;
  logic               q_not_empty;
  logic               q_room2;
  logic [Q_CNT_W-1:0] q_count;

  // register write lands in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    radix_d = radix_q;
    if (cfg_wr && paddr[2] == REG_RADIX_LOG2) begin
      radix_d = pwdata[RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_LOG2_RST;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign prdata = (paddr[2] == REG_RADIX_LOG2) ? PDATA_W'(radix_q) : '0;

  // 0 behaves as binary, 7 as radix 64
  always_comb begin
    radix_eff = radix_q;
    if (radix_q < RADIX_LOG2_MIN) begin
      radix_eff = RADIX_LOG2_MIN;
    end else if (radix_q > RADIX_LOG2_MAX) begin
      radix_eff = RADIX_LOG2_MAX;
    end
  end

  assign s_axis_tready = q_room2;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_pop       = m_axis_tvalid && m_axis_tready;

  rdl_digit_map u_digit_map (
    .char_i       (s_axis_tdata),
    .radix_log2_i (radix_eff),
    .digit_o      (digit)
  );

  rdl_packer #(
    .LIMB_BITS (LIMB_BITS)
  ) u_packer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .char_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .radix_log2_i (radix_eff),
    .digit_i      (digit),
    .res0_o       (res0),
    .res1_o       (res1),
    .n_push_o     (n_push)
  );

  rdl_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res0_i      (res0),
    .res1_i      (res1),
    .n_push_i    (n_push),
    .pop_i       (out_pop),
    .head_o      (head),
    .not_empty_o (q_not_empty),
    .room2_o     (q_room2),
    .count_o     (q_count)
  );

  assign m_axis_tvalid = q_not_empty;
  assign m_axis_tdata  = OUT_TDATA_W'(head.limb_value);
  assign m_axis_tlast  = head.limb_last;
  assign m_axis_tuser  = {head.invalid, head.negative};

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  // an error transaction always closes the number
  a_invalid_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("error result without tlast or with negative");

  // sign only appears on a final limb
  a_neg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("negative flag on a non-final limb");

  // nothing is pushed without an accepted character
  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |-> n_push == 2'd0)
    else $error("result pushed without input transaction");

endmodule

// ===== test/pow2_radix_digits_to_limbs_core_test.sv =====
`timescale 1ns / 1ps
module pow2_radix_digits_to_limbs_core_test;
  import rdl_pkg::*;

  localparam int LIMB = LIMB_W;
  localparam int NO_DIGIT = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 150;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    bit               cfg_en;
    logic [RADIX_W-1:0] cfg_val;
    logic [CHAR_W-1:0] ch;
    bit               last;
    bit               typed;
    bit               has_res;
    result_t          res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [CHAR_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // predictor copy of the block state and its register
  logic [LIMB_W-1:0] limb_buf;
  int unsigned bits_held;
  bit digit_taken;
  bit dropping;
  logic [RADIX_W-1:0] radix_q;

  result_t limbs_due[$];
  row_t rows[$];
  int errors = 0;
  int chars_sent = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int cycle_count = 0;

  pow2_radix_digits_to_limbs_core #(.LIMB_BITS(LIMB)) dut (.*);

  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // limb checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (limbs_due.size() == 0) begin
        $display("%0t: unexpected limb tdata=%h tlast=%b tuser=%b", $time,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
        errors++;
      end else begin
        e = limbs_due.pop_front();
        if (m_axis_tdata !== {{(OUT_TDATA_W-LIMB_W){1'b0}}, e.limb_value}) begin
          $display("%0t: limb_value expected %h actual %h", $time, e.limb_value,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== e.limb_last) begin
          $display("%0t: limb_last expected %b actual %b", $time, e.limb_last,
                   m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser[0] !== e.negative) begin
          $display("%0t: negative expected %b actual %b", $time, e.negative,
                   m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== e.invalid) begin
          $display("%0t: invalid expected %b actual %b", $time, e.invalid,
                   m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  function automatic result_t limb_result(logic [LIMB_W-1:0] v, bit l, bit neg, bit inv);
    result_t r;
    r.limb_value = v;
    r.limb_last = l;
    r.negative = neg;
    r.invalid = inv;
    return r;
  endfunction

  function automatic void clear_number();
    limb_buf = '0;
    bits_held = 0;
    digit_taken = 1'b0;
    dropping = 1'b0;
  endfunction

  // out-of-range register values clamp to 1 and 6 bits per digit
  function automatic int eff_bits();
    if (radix_q < RADIX_LOG2_MIN) return int'(RADIX_LOG2_MIN);
    if (radix_q > RADIX_LOG2_MAX) return int'(RADIX_LOG2_MAX);
    return int'(radix_q);
  endfunction

  function automatic int digit_of(logic [CHAR_W-1:0] c, int r);
    logic [CHAR_W-1:0] u;
    u = c;
    if (r <= FOLD_MAX_LOG2 && c >= CH_LA && c <= CH_LZ) u = c - CASE_GAP;
    if (u >= CH_0 && u <= CH_9) return int'(u - CH_0);
    if (u >= CH_UA && u <= CH_UZ) return int'(u - CH_UA) + int'(DIG_UPPER);
    if (u >= CH_LA && u <= CH_LZ) return int'(u - CH_LA) + int'(DIG_LOWER);
    if (u == CH_PLUS) return int'(DIG_PLUS);
    if (u == CH_SLASH) return int'(DIG_SLASH);
    return NO_DIGIT;
  endfunction

  // limbs caused by one character; returns how many (0..2)
  function automatic int predict_limbs(input logic [CHAR_W-1:0] c, input bit l,
                                       output result_t r0, output result_t r1);
    int r;
    int d;
    int n;
    logic [63:0] wide;
    result_t fin;
    r0 = '0;
    r1 = '0;
    n = 0;
    if (dropping) begin
      // rest of a broken number, up to its last character
      if (l) clear_number();
    end else if (l && c == CH_MINUS) begin
      r0 = limb_result(limb_buf, 1'b1, 1'b1, 1'b0);
      n = 1;
      clear_number();
    end else if (!digit_taken && (c == CH_CR || c == CH_LF)) begin
      // line ends ahead of the first digit are skipped
      if (l) begin
        r0 = limb_result(limb_buf, 1'b1, 1'b0, 1'b0);
        n = 1;
        clear_number();
      end
    end else begin
      r = eff_bits();
      d = digit_of(c, r);
      if (d >= (1 << r)) begin
        r0 = limb_result('0, 1'b1, 1'b0, 1'b1);
        n = 1;
        clear_number();
        dropping = !l;
      end else begin
        digit_taken = 1'b1;
        if (bits_held + r >= LIMB) begin
          wide = {{(64-LIMB_W){1'b0}}, limb_buf} | (64'(d) << bits_held);
          r0 = limb_result(wide[LIMB_W-1:0], 1'b0, 1'b0, 1'b0);
          n = 1;
          wide = 64'(d) >> (LIMB - bits_held);
          limb_buf = wide[LIMB_W-1:0];
          bits_held = bits_held + r - LIMB;
        end else begin
          wide = 64'(d) << bits_held;
          limb_buf = limb_buf | wide[LIMB_W-1:0];
          bits_held = bits_held + r;
        end
        if (l) begin
          fin = limb_result(limb_buf, 1'b1, 1'b0, 1'b0);
          if (n == 0) r0 = fin;
          else r1 = fin;
          n++;
          clear_number();
        end
      end
    end
    return n;
  endfunction

  // offer one character, return at the edge where it is taken
  task automatic drive_char(input logic [CHAR_W-1:0] c, input bit l);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= l;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic feed(input logic [CHAR_W-1:0] c, input bit l);
    result_t r0;
    result_t r1;
    int n;
    drive_char(c, l);
    n = predict_limbs(c, l, r0, r1);
    if (n > 0) limbs_due.push_back(r0);
    if (n > 1) limbs_due.push_back(r1);
    chars_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (limbs_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_RADIX_LOG2, 2'b00};
    pwdata <= PDATA_W'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    radix_q = v;
    @(negedge clk_i);
    // register reads back what was written
    if (prdata !== PDATA_W'(v)) begin
      $display("%0t: radix_log2 read expected %h actual %h", $time, v, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_row(input bit cfg_en, input logic [RADIX_W-1:0] cfg_val,
                         input logic [CHAR_W-1:0] ch, input bit l, input bit typed,
                         input bit has_res, input result_t res);
    row_t w;
    w.cfg_en = cfg_en;
    w.cfg_val = cfg_val;
    w.ch = ch;
    w.last = l;
    w.typed = typed;
    w.has_res = has_res;
    w.res = res;
    rows.push_back(w);
  endtask

  // one number, least significant character first; mostly well formed
  task automatic send_number();
    int r;
    int k;
    int len;
    int d;
    bit minus;
    logic [CHAR_W-1:0] c;
    r = eff_bits();
    k = $urandom_range(0, 99);
    if (k < 6) begin
      // nothing but line ends
      repeat ($urandom_range(0, 3)) feed($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
      feed($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b1);
    end else begin
      if (k < 20) repeat ($urandom_range(1, 2)) feed($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
      // some numbers long enough to fill several limbs
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * LIMB / r + 2)
                                        : $urandom_range(1, 12);
      minus = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 3) begin
          c = CHAR_W'($urandom_range(0, 255));
        end else begin
          d = $urandom_range(0, (1 << r) - 1);
          if (d < DIG_UPPER) begin
            c = CHAR_W'(int'(CH_0) + d);
          end else if (d < DIG_LOWER) begin
            c = CHAR_W'(int'(CH_UA) + d - int'(DIG_UPPER));
            if (r <= FOLD_MAX_LOG2 && $urandom_range(0, 1)) c = c + CASE_GAP;
          end else if (d < DIG_PLUS) begin
            c = CHAR_W'(int'(CH_LA) + d - int'(DIG_LOWER));
          end else begin
            c = (d == DIG_PLUS) ? CH_PLUS : CH_SLASH;
          end
        end
        feed(c, (i == len - 1) && !minus);
      end
      if (minus) feed(CH_MINUS, 1'b1);
    end
  endtask

  initial begin
    int n;
    result_t r0;
    result_t r1;
    row_t w;
    logic [RADIX_W-1:0] phase_radix [6];
    phase_radix = '{3'd1, 3'd6, 3'd5, 3'd3, 3'd2, 3'd7};

    // directed table; typed results at reset radix 16 unless a row sets the radix
    add_row(0, 0, CH_0, 1, 1, 1, limb_result(60'h0, 1, 0, 0));
    add_row(0, 0, CH_LA + 8'd5, 1, 1, 1, limb_result(60'hF, 1, 0, 0));   // 'f' folds
    add_row(0, 0, CH_UA + 8'd5, 0, 1, 0, '0);
    add_row(0, 0, CH_MINUS, 1, 1, 1, limb_result(60'hF, 1, 1, 0));
    add_row(0, 0, CH_CR, 0, 1, 0, '0);                                   // skipped
    add_row(0, 0, CH_LF, 1, 1, 1, limb_result(60'h0, 1, 0, 0));
    add_row(0, 0, CH_UA + 8'd6, 0, 1, 1, limb_result(60'h0, 1, 0, 1));   // 'G' bad
    add_row(0, 0, 8'h80, 1, 1, 0, '0);                                   // dropped
    add_row(0, 0, CH_0 + 8'd1, 0, 1, 0, '0);
    add_row(0, 0, CH_CR, 1, 1, 1, limb_result(60'h0, 1, 0, 1));          // cr after digit
    add_row(0, 0, CH_MINUS, 0, 1, 1, limb_result(60'h0, 1, 0, 1));       // minus not last
    add_row(0, 0, CH_0 + 8'd5, 1, 1, 0, '0);
    add_row(0, 0, 8'hFF, 1, 1, 1, limb_result(60'h0, 1, 0, 1));
    add_row(1, 3'd0, CH_0 + 8'd1, 1, 1, 1, limb_result(60'h1, 1, 0, 0)); // clamps to binary
    add_row(0, 0, CH_0 + 8'd2, 1, 1, 1, limb_result(60'h0, 1, 0, 1));
    add_row(1, 3'd7, CH_SLASH, 1, 1, 1, limb_result(60'h3F, 1, 0, 0));
    // base 64: ten digits fill one limb exactly, then a zero final limb
    add_row(1, 3'd6, CH_PLUS, 0, 0, 0, '0);
    repeat (8) add_row(0, 0, CH_SLASH, 0, 0, 0, '0);
    add_row(0, 0, CH_LZ, 1, 0, 0, '0);

    clear_number();
    radix_q = RADIX_LOG2_RST;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle = 28;
    recv_idle = 74;
    foreach (rows[i]) begin
      w = rows[i];
      if (w.cfg_en) begin
        stop_sending();
        wait_drained();
        write_radix(w.cfg_val);
      end
      drive_char(w.ch, w.last);
      n = predict_limbs(w.ch, w.last, r0, r1);
      if (w.typed) begin
        if (w.has_res) limbs_due.push_back(w.res);
      end else begin
        if (n > 0) limbs_due.push_back(r0);
        if (n > 1) limbs_due.push_back(r1);
      end
    end

    // random numbers, two phases per idle pattern, new radix each phase
    for (int p = 0; p < 6; p++) begin
      stop_sending();
      wait_drained();
      write_radix(phase_radix[p]);
      case (p / 2)
        0: begin
          send_idle = 28;
          recv_idle = 74;
        end
        1: begin
          send_idle = 74;
          recv_idle = 28;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      // long receiver stall while characters keep coming, fills the queue
      if (p == 0) hold_req++;
      n = chars_sent + PHASE_CHARS;
      while (chars_sent < n) send_number();
    end

    stop_sending();
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rdl_pkg.sv
src/rdl_digit_map.sv
src/rdl_packer.sv
src/rdl_out_queue.sv
src/pow2_radix_digits_to_limbs_core.sv
test/pow2_radix_digits_to_limbs_core_test.sv
